/* design/kct_pkg.sv */
// Shared types and constants for the keyed counter table.
package kct_pkg;

  localparam int COUNT_W = 31;
  localparam int AMT_W   = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_INVALID_KEY = 3'd0,
    ST_BAD_AMOUNT  = 3'd1,
    ST_ADDED       = 3'd2,
    ST_INSERTED    = 3'd3,
    ST_DECREMENTED = 3'd4,
    ST_REMOVED     = 3'd5,
    ST_NOT_FOUND   = 3'd6,
    ST_FULL        = 3'd7
  } status_t;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE
  } state_t;

  // search token flags, handed from cell to cell
  typedef struct packed {
    logic active;
    logic found;
    logic free_found;
  } srch_flags_t;

  // write-back command, broadcast to all cells
  typedef struct packed {
    logic we;
    logic clr;
  } wr_ctl_t;

endpackage

/* design/kct_cell.sv */
// One table slot: holds key, count and valid, and forwards the search token.
module kct_cell #(
  parameter int KEY_BITS = 16,
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kct_pkg::srch_flags_t             s_flags_in,
  input  logic [KEY_BITS-1:0]              s_key_in,
  input  logic [IDX_W-1:0]                 s_found_idx_in,
  input  logic [kct_pkg::COUNT_W-1:0]      s_found_count_in,
  input  logic [IDX_W-1:0]                 s_free_idx_in,
  output kct_pkg::srch_flags_t             s_flags_out,
  output logic [KEY_BITS-1:0]              s_key_out,
  output logic [IDX_W-1:0]                 s_found_idx_out,
  output logic [kct_pkg::COUNT_W-1:0]      s_found_count_out,
  output logic [IDX_W-1:0]                 s_free_idx_out,
  input  kct_pkg::wr_ctl_t                 wr_ctl,
  input  logic [IDX_W-1:0]                 wr_idx,
  input  logic [KEY_BITS-1:0]              wr_key,
  input  logic [kct_pkg::COUNT_W-1:0]      wr_count
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                         valid_r;
  logic [KEY_BITS-1:0]          key_r;
  logic [kct_pkg::COUNT_W-1:0]  count_r;

  kct_pkg::srch_flags_t         flags_r;
  logic [KEY_BITS-1:0]          s_key_r;
  logic [IDX_W-1:0]             found_idx_r;
  logic [kct_pkg::COUNT_W-1:0]  found_count_r;
  logic [IDX_W-1:0]             free_idx_r;

  logic hit;
  logic take_free;
  logic wr_hit;

  assign hit       = s_flags_in.active && !s_flags_in.found && valid_r && (key_r == s_key_in);
  assign take_free = s_flags_in.active && !s_flags_in.free_found && !valid_r;
  assign wr_hit    = wr_ctl.we && (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit) begin
      valid_r <= !wr_ctl.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit && !wr_ctl.clr) begin
      key_r   <= wr_key;
      count_r <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r.active     <= s_flags_in.active;
      flags_r.found      <= s_flags_in.found || hit;
      flags_r.free_found <= s_flags_in.free_found || take_free;
    end
  end

  always_ff @(posedge clk) begin
    s_key_r       <= s_key_in;
    found_idx_r   <= hit ? MY_IDX : s_found_idx_in;
    found_count_r <= hit ? count_r : s_found_count_in;
    free_idx_r    <= take_free ? MY_IDX : s_free_idx_in;
  end

  assign s_flags_out       = flags_r;
  assign s_key_out         = s_key_r;
  assign s_found_idx_out   = found_idx_r;
  assign s_found_count_out = found_count_r;
  assign s_free_idx_out    = free_idx_r;

endmodule

/* design/kct_ctrl.sv */
// Request sequencer: launches the search, decides the update, writes back, holds the result.
module kct_ctrl #(
  parameter int KEY_BITS = 16,
  parameter int IDX_W    = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [KEY_BITS-1:0]              in_key,
  input  logic [kct_pkg::AMT_W-1:0]        in_amount,
  output logic                             out_valid,
  input  logic                             out_ready,
  output kct_pkg::status_t                 out_status,
  output logic [kct_pkg::COUNT_W-1:0]      out_count,
  output kct_pkg::srch_flags_t             head_flags,
  output logic [KEY_BITS-1:0]              head_key,
  input  kct_pkg::srch_flags_t             tail_flags,
  input  logic [KEY_BITS-1:0]              tail_key,
  input  logic [IDX_W-1:0]                 tail_found_idx,
  input  logic [kct_pkg::COUNT_W-1:0]      tail_found_count,
  input  logic [IDX_W-1:0]                 tail_free_idx,
  output kct_pkg::wr_ctl_t                 wr_ctl,
  output logic [IDX_W-1:0]                 wr_idx,
  output logic [KEY_BITS-1:0]              wr_key,
  output logic [kct_pkg::COUNT_W-1:0]      wr_count
);

  localparam int CW = kct_pkg::COUNT_W;
  localparam int AW = kct_pkg::AMT_W;

  kct_pkg::state_t  state_r, state_nxt;

  kct_pkg::req_t    req_type_r;
  logic [AW-1:0]    amount_r;

  kct_pkg::status_t pend_status_r, pend_status_nxt;
  logic [CW-1:0]    pend_count_r, pend_count_nxt;
  logic             pend_we_r, pend_we_nxt;
  logic             pend_clr_r, pend_clr_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [KEY_BITS-1:0] pend_key_r;

  logic             out_valid_r;
  kct_pkg::status_t out_status_r;
  logic [CW-1:0]    out_count_r;

  logic             accept;
  logic             out_free;
  logic             finish;
  logic             amt_bad;
  logic [AW-1:0]    sum;
  logic [CW-1:0]    diff;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == kct_pkg::S_WRITE) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kct_pkg::S_IDLE:   if (in_valid) state_nxt = kct_pkg::S_SEARCH;
      kct_pkg::S_SEARCH: if (tail_flags.active) state_nxt = kct_pkg::S_WRITE;
      kct_pkg::S_WRITE:  if (out_free) state_nxt = kct_pkg::S_IDLE;
      default:           state_nxt = kct_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready          = 1'b0;
    head_flags        = '0;
    wr_ctl            = '0;
    case (state_r)
      kct_pkg::S_IDLE: begin
        in_ready          = 1'b1;
        head_flags.active = in_valid;
      end
      kct_pkg::S_WRITE: begin
        wr_ctl.we  = pend_we_r && out_free;
        wr_ctl.clr = pend_clr_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign head_key = in_key;
  assign wr_idx   = pend_idx_r;
  assign wr_key   = pend_key_r;
  assign wr_count = pend_count_r;

  // update decision at the end of the search
  assign amt_bad = (amount_r == '0) || amount_r[AW-1];
  assign sum     = {1'b0, tail_found_count} + {1'b0, amount_r[CW-1:0]};
  assign diff    = tail_found_count - amount_r[CW-1:0];

  always_comb begin
    pend_status_nxt = kct_pkg::ST_INVALID_KEY;
    pend_count_nxt  = '0;
    pend_we_nxt     = 1'b0;
    pend_clr_nxt    = 1'b0;
    pend_idx_nxt    = tail_found_idx;
    if (tail_key == '0) begin
      pend_status_nxt = kct_pkg::ST_INVALID_KEY;
    end else if (amt_bad) begin
      pend_status_nxt = kct_pkg::ST_BAD_AMOUNT;
      pend_count_nxt  = tail_flags.found ? tail_found_count : '0;
    end else if (req_type_r == kct_pkg::REQ_ADD) begin
      if (tail_flags.found) begin
        pend_status_nxt = kct_pkg::ST_ADDED;
        pend_count_nxt  = sum[CW] ? kct_pkg::COUNT_MAX : sum[CW-1:0];
        pend_we_nxt     = 1'b1;
      end else if (tail_flags.free_found) begin
        pend_status_nxt = kct_pkg::ST_INSERTED;
        pend_count_nxt  = amount_r[CW-1:0];
        pend_we_nxt     = 1'b1;
        pend_idx_nxt    = tail_free_idx;
      end else begin
        pend_status_nxt = kct_pkg::ST_FULL;
      end
    end else begin
      if (!tail_flags.found) begin
        pend_status_nxt = kct_pkg::ST_NOT_FOUND;
      end else if ({1'b0, tail_found_count} <= amount_r) begin
        pend_status_nxt = kct_pkg::ST_REMOVED;
        pend_we_nxt     = 1'b1;
        pend_clr_nxt    = 1'b1;
      end else begin
        pend_status_nxt = kct_pkg::ST_DECREMENTED;
        pend_count_nxt  = diff;
        pend_we_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kct_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= kct_pkg::req_t'(in_req_type);
      amount_r   <= in_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_we_r <= 1'b0;
    end else if (state_r == kct_pkg::S_SEARCH && tail_flags.active) begin
      pend_we_r <= pend_we_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == kct_pkg::S_SEARCH && tail_flags.active) begin
      pend_status_r <= pend_status_nxt;
      pend_count_r  <= pend_count_nxt;
      pend_clr_r    <= pend_clr_nxt;
      pend_idx_r    <= pend_idx_nxt;
      pend_key_r    <= tail_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= pend_status_r;
      out_count_r  <= pend_count_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

/* design/keyed_counter_table_top.sv */
// Keyed counter table top level: cell chain plus request sequencer.
//
// Each request walks a chain of TABLE_DEPTH slot cells, one cell per cycle, which
// finds the lowest matching slot and the lowest free slot. The sequencer then
// decides the update, writes it back to the chosen cell and loads the result
// register. One request is in flight at a time; with the result taken promptly its
// time is set by the length of the chain. The result register lets the next request
// enter while a result waits. Slot valid bits clear at reset.
module keyed_counter_table_top #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // key, amount, zero pad (from bit 0 up)
  input  logic [((KEY_BITS+kct_pkg::AMT_W+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic                                        in_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // new_count, zero pad (from bit 0 up)
  output logic [((kct_pkg::COUNT_W+7)/8)*8-1:0]        out_tdata,
  // status
  output logic [2:0]                                  out_tuser
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CW     = kct_pkg::COUNT_W;
  localparam int AW     = kct_pkg::AMT_W;
  localparam int OUT_DW = ((CW+7)/8)*8;

  kct_pkg::srch_flags_t chain_flags       [TABLE_DEPTH+1];
  logic [KEY_BITS-1:0]  chain_key         [TABLE_DEPTH+1];
  logic [IDX_W-1:0]     chain_found_idx   [TABLE_DEPTH+1];
  logic [CW-1:0]        chain_found_count [TABLE_DEPTH+1];
  logic [IDX_W-1:0]     chain_free_idx    [TABLE_DEPTH+1];

  kct_pkg::wr_ctl_t     wr_ctl;
  logic [IDX_W-1:0]     wr_idx;
  logic [KEY_BITS-1:0]  wr_key;
  logic [CW-1:0]        wr_count;

  kct_pkg::status_t     out_status;
  logic [CW-1:0]        out_count;

  assign chain_found_idx[0]   = '0;
  assign chain_found_count[0] = '0;
  assign chain_free_idx[0]    = '0;

  kct_ctrl #(
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_req_type      (in_tuser),
    .in_key           (in_tdata[KEY_BITS-1:0]),
    .in_amount        (in_tdata[KEY_BITS+AW-1:KEY_BITS]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_status       (out_status),
    .out_count        (out_count),
    .head_flags       (chain_flags[0]),
    .head_key         (chain_key[0]),
    .tail_flags       (chain_flags[TABLE_DEPTH]),
    .tail_key         (chain_key[TABLE_DEPTH]),
    .tail_found_idx   (chain_found_idx[TABLE_DEPTH]),
    .tail_found_count (chain_found_count[TABLE_DEPTH]),
    .tail_free_idx    (chain_free_idx[TABLE_DEPTH]),
    .wr_ctl           (wr_ctl),
    .wr_idx           (wr_idx),
    .wr_key           (wr_key),
    .wr_count         (wr_count)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kct_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk               (clk),
      .rst_n             (rst_n),
      .s_flags_in        (chain_flags[i]),
      .s_key_in          (chain_key[i]),
      .s_found_idx_in    (chain_found_idx[i]),
      .s_found_count_in  (chain_found_count[i]),
      .s_free_idx_in     (chain_free_idx[i]),
      .s_flags_out       (chain_flags[i+1]),
      .s_key_out         (chain_key[i+1]),
      .s_found_idx_out   (chain_found_idx[i+1]),
      .s_found_count_out (chain_found_count[i+1]),
      .s_free_idx_out    (chain_free_idx[i+1]),
      .wr_ctl            (wr_ctl),
      .wr_idx            (wr_idx),
      .wr_key            (wr_key),
      .wr_count          (wr_count)
    );
  end

  assign out_tdata = {{(OUT_DW-CW){1'b0}}, out_count};
  assign out_tuser = out_status;

endmodule

/* design/kct_checker.sv */
// Port-level checks for the keyed counter table, bound to the top level.
module kct_checker #(
  parameter int KEY_BITS = 16
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_tvalid,
  input logic                                        in_tready,
  input logic [((KEY_BITS+kct_pkg::AMT_W+7)/8)*8-1:0] in_tdata,
  input logic                                        in_tuser,
  input logic                                        out_tvalid,
  input logic                                        out_tready,
  input logic [((kct_pkg::COUNT_W+7)/8)*8-1:0]        out_tdata,
  input logic [2:0]                                  out_tuser
);

  localparam int CW = kct_pkg::COUNT_W;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a request is in flight");

  // an accepted request yields no result in the next cycle beyond a waiting one
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // absent-key outcomes report a zero count
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == kct_pkg::ST_INVALID_KEY || out_tuser == kct_pkg::ST_REMOVED ||
                   out_tuser == kct_pkg::ST_NOT_FOUND || out_tuser == kct_pkg::ST_FULL)
    |-> out_tdata[CW-1:0] == '0)
    else $error("nonzero count with absent key");

  // no result directly after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind keyed_counter_table_top kct_checker #(.KEY_BITS(KEY_BITS)) u_kct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/tb_kct_checker.sv */
// Checker for the keyed counter table: tracks the table, predicts each result and compares.
`timescale 1ns / 100ps

module tb_kct_checker
  import kct_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int KEY_W = 16,
  parameter int IN_W  = 48,
  parameter int OUT_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic [2:0]       out_tuser,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } tally_t;

  tally_t             tally_q[$];
  logic [KEY_W-1:0]   slot_key  [DEPTH];
  logic [COUNT_W-1:0] slot_cnt  [DEPTH];
  logic               slot_used [DEPTH];
  int                 errors = 0;

  function automatic tally_t apply_request(req_t op, logic [KEY_W-1:0] key,
                                           logic [AMT_W-1:0] amt);
    tally_t      r;
    int          hit;
    int          free_slot;
    logic [31:0] sum;
    r.status  = ST_INVALID_KEY;
    r.count   = '0;
    hit       = -1;
    free_slot = -1;
    // walk down so the lowest index wins
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    if (key == '0) begin
      r.status = ST_INVALID_KEY;
    end else if (amt == '0 || amt[AMT_W-1]) begin
      r.status = ST_BAD_AMOUNT;
      if (hit >= 0) r.count = slot_cnt[hit];
    end else if (op == REQ_ADD) begin
      if (hit >= 0) begin
        sum = {1'b0, slot_cnt[hit]} + amt;
        if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
        slot_cnt[hit] = sum[COUNT_W-1:0];
        r.status = ST_ADDED;
        r.count  = sum[COUNT_W-1:0];
      end else if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = key;
        slot_cnt[free_slot]  = amt[COUNT_W-1:0];
        r.status = ST_INSERTED;
        r.count  = amt[COUNT_W-1:0];
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else if ({1'b0, slot_cnt[hit]} <= amt) begin
        slot_used[hit] = 1'b0;
        r.status = ST_REMOVED;
      end else begin
        slot_cnt[hit] = slot_cnt[hit] - amt[COUNT_W-1:0];
        r.status = ST_DECREMENTED;
        r.count  = slot_cnt[hit];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tally_t want;
    tally_t got;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      tally_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.count  = out_tdata[COUNT_W-1:0];
        if (tally_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with nothing pending: status %0d count %0d",
                     $realtime, out_tuser, got.count);
        end else begin
          want = tally_q.pop_front();
          if (got.status !== want.status || got.count !== want.count) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected status %0d count %0d, got status %0d count %0d",
                       $realtime, want.status, want.count, out_tuser, got.count);
          end
        end
      end
      if (in_tvalid && in_tready)
        tally_q.push_back(apply_request(req_t'(in_tuser), in_tdata[KEY_W-1:0],
                                        in_tdata[KEY_W+AMT_W-1:KEY_W]));
    end
    pending    <= tally_q.size();
    fail_count <= errors;
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the keyed counter table: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module tb_top;
  import kct_pkg::*;

  localparam int DEPTH     = 32;
  localparam int KEY_W     = 16;
  localparam int IN_W      = ((KEY_W + AMT_W + 7) / 8) * 8;
  localparam int OUT_W     = ((COUNT_W + 7) / 8) * 8;
  localparam int WATCHDOG  = 3000;
  localparam int HOLD_AT   = 5000;
  localparam int HOLD_LEN  = 400;
  localparam int POOL_SIZE = 40;
  localparam int PHASE_LEN = 200;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // key, amount (from bit 0 up)
  logic             in_tuser;   // req_type
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // new_count, pad (from bit 0 up)
  logic [2:0]       out_tuser;  // status
  int               fail_count;
  int               pending;
  int               stall_cycles = 0;
  int               burst_left = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keyed_counter_table_top #(.TABLE_DEPTH(DEPTH), .KEY_BITS(KEY_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tb_kct_checker #(.DEPTH(DEPTH), .KEY_W(KEY_W), .IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic put_req(req_t op, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amt);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {amt, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_idle(int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send(req_t op, logic [KEY_W-1:0] key, logic [AMT_W-1:0] amt);
    if (burst_left == 0) begin
      hold_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      burst_left = $urandom_range(1, 24);
    end
    put_req(op, key, amt);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      6:       return $urandom_range(32'h7FFF_FFFF, 1);
      7:       return $urandom_range(32'h7FFF_FFFF, 32'h7FFF_0000);
      8:       return $urandom_range(20000, 1);
      default: return $urandom_range(200, 1);
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] pick_bad_amount();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'h8000_0000;
      default: return $urandom() | 32'h8000_0000;
    endcase
  endfunction

  initial begin
    int cyc;
    int mode;
    int left;
    logic [7:0] mask;
    out_tready = 1'b0;
    cyc  = 0;
    mode = 0;
    left = 0;
    mask = 8'b1011_0110;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HOLD_AT) begin
        out_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 9) >= 3);
        2: begin
          out_tready = mask[0];
          mask = {mask[0], mask[7:1]};
        end
        default: out_tready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    int add_pct [3];
    int r;
    req_t op;
    logic [KEY_W-1:0] key;
    add_pct[0] = 80;
    add_pct[1] = 30;
    add_pct[2] = 55;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(16'hFFFF, 1));
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send(REQ_ADD,    16'h0000, 32'd5);
    send(REQ_REMOVE, 16'h0000, 32'd0);
    send(REQ_ADD,    16'h0001, 32'd0);
    send(REQ_ADD,    16'h0001, 32'hFFFF_FFFF);
    send(REQ_REMOVE, 16'h0001, 32'h8000_0000);
    send(REQ_ADD,    16'hFFFF, 32'h7FFF_FFFF);
    send(REQ_ADD,    16'hFFFF, 32'd1);
    send(REQ_ADD,    16'hFFFF, 32'h8000_0001);
    send(REQ_ADD,    16'h0001, 32'h5555_5555);
    send(REQ_REMOVE, 16'hFFFF, 32'h7FFF_FFFE);
    send(REQ_REMOVE, 16'hFFFF, 32'd1);
    send(REQ_REMOVE, 16'hFFFF, 32'd3);
    send(REQ_ADD,    16'hAAAA, 32'd7);
    send(REQ_REMOVE, 16'h0001, 32'h7FFF_FFFF);
    send(REQ_ADD,    16'h5555, 32'h2AAA_AAAA);
    send(REQ_REMOVE, 16'hAAAA, 32'd2);
    send(REQ_REMOVE, 16'h5555, 32'h2AAA_AAAA);

    for (int p = 0; p < 3; p++) begin
      drain();
      for (int n = 0; n < PHASE_LEN; n++) begin
        r   = $urandom_range(0, 99);
        op  = ($urandom_range(0, 99) < add_pct[p]) ? REQ_ADD : REQ_REMOVE;
        key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(16'hFFFF, 1))
                                          : key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 4) begin
          send(op, '0, $urandom());
        end else if (r < 10) begin
          send(op, key, pick_bad_amount());
        end else begin
          send(op, key, pick_amount());
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
